### hw/rtl/gif_lzw_encoder_core_assert.svh
// Assertion macros for the LZW encoder datapath.
`ifndef GIF_LZW_ENCODER_CORE_ASSERT_SVH
`define GIF_LZW_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GLE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define GLE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/gle_pkg.sv
// Types, constants and helpers shared by the LZW encoder modules.
`default_nettype none
package gle_pkg;

	localparam int SYM_W = 8;
	localparam int ACC_W = 24;
	localparam int BCNT_W = 5;
	localparam int SIZE_W = 4;
	localparam int SIZE_LO = 2;
	localparam int SIZE_HI = 8;
	localparam int SIZE_RST = 2;

	// One pixel transfer.
	typedef struct packed {
		logic [7:0] pixel_index;
		logic       last_pixel;
	} pixel_t;

	// One byte transfer of the code stream.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} stream_t;

	// Which code the bit packer appends.
	typedef enum logic [1:0] {
		SEL_CLEAR,
		SEL_PREFIX,
		SEL_END
	} code_sel_t;

	// Controller states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INIT,
		ST_EMIT_CLR,
		ST_DRAIN_CLR,
		ST_SYM,
		ST_SEARCH,
		ST_EMIT_PFX,
		ST_DRAIN_PFX,
		ST_UPDATE,
		ST_EMIT_FULL,
		ST_DRAIN_FULL,
		ST_RESTART,
		ST_LAST_CHK,
		ST_EMIT_LPFX,
		ST_DRAIN_LPFX,
		ST_EMIT_END,
		ST_DRAIN_END,
		ST_FLUSH
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic      accept;
		logic      init;
		logic      emit;
		code_sel_t emit_sel;
		logic      drain;
		logic      final_flag;
		logic      flush;
		logic      first_sym;
		logic      srch_start;
		logic      srch_run;
		logic      take_hit;
		logic      update;
		logic      restart;
		logic      finish;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic started;
		logic pvalid;
		logic last;
		logic ge8;
		logic bnz;
		logic out_free;
		logic srch_done;
		logic srch_hit;
		logic full;
	} stat_t;

	// Clamp the minimum code size to the legal GIF range.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		r = s;
		if (s < SIZE_W'(SIZE_LO)) r = SIZE_W'(SIZE_LO);
		if (s > SIZE_W'(SIZE_HI)) r = SIZE_W'(SIZE_HI);
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/gif_lzw_encoder_core.sv
// GIF LZW encoder: variable-width codes packed LSB first into bytes, one byte per transfer.
// Pixels are taken one at a time: pixel_stall stays high while a pixel is processed, through
// its dictionary scan, code emission, byte draining and any output stalls.
// A byte is presented the cycle after it is packed.
// Reset clears all control state, not the dictionary.
`default_nettype none
module gif_lzw_encoder_core #(
	parameter int MAX_CODE_BITS = 12
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [gle_pkg::SIZE_W-1:0] cfg_data,
	input  wire logic                       pixel_valid,
	output logic                            pixel_stall,
	input  wire gle_pkg::pixel_t            pixel,
	output logic                            stream_valid,
	input  wire logic                       stream_stall,
	output gle_pkg::stream_t                stream
);

	gle_pkg::cmd_t  cmd;
	gle_pkg::stat_t stat;

	// Register writes are taken at any time.
	assign cfg_ready = 1'b1;

	gle_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	gle_datapath #(
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.pixel        (pixel),
		.stream       (stream),
		.stream_valid (stream_valid),
		.stream_stall (stream_stall),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule
`default_nettype wire

### hw/rtl/gle_ctrl.sv
// Sequencing state machine of the LZW encoder.
`default_nettype none
module gle_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pixel_valid,
	output logic               pixel_stall,
	input  wire gle_pkg::stat_t stat,
	output gle_pkg::cmd_t      cmd
);

	gle_pkg::state_t state_q, state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gle_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gle_pkg::ST_IDLE: begin
				if (pixel_valid) begin
					state_nxt = stat.started ? gle_pkg::ST_SYM : gle_pkg::ST_INIT;
				end
			end
			gle_pkg::ST_INIT:      state_nxt = gle_pkg::ST_EMIT_CLR;
			gle_pkg::ST_EMIT_CLR:  state_nxt = gle_pkg::ST_DRAIN_CLR;
			gle_pkg::ST_DRAIN_CLR: begin
				if (!stat.ge8) state_nxt = gle_pkg::ST_SYM;
			end
			gle_pkg::ST_SYM: begin
				state_nxt = stat.pvalid ? gle_pkg::ST_SEARCH : gle_pkg::ST_LAST_CHK;
			end
			gle_pkg::ST_SEARCH: begin
				if (stat.srch_hit) state_nxt = gle_pkg::ST_LAST_CHK;
				else if (stat.srch_done) state_nxt = gle_pkg::ST_EMIT_PFX;
			end
			gle_pkg::ST_EMIT_PFX:  state_nxt = gle_pkg::ST_DRAIN_PFX;
			gle_pkg::ST_DRAIN_PFX: begin
				if (!stat.ge8) state_nxt = gle_pkg::ST_UPDATE;
			end
			gle_pkg::ST_UPDATE: begin
				state_nxt = stat.full ? gle_pkg::ST_EMIT_FULL : gle_pkg::ST_LAST_CHK;
			end
			gle_pkg::ST_EMIT_FULL:  state_nxt = gle_pkg::ST_DRAIN_FULL;
			gle_pkg::ST_DRAIN_FULL: begin
				if (!stat.ge8) state_nxt = gle_pkg::ST_RESTART;
			end
			gle_pkg::ST_RESTART:  state_nxt = gle_pkg::ST_LAST_CHK;
			gle_pkg::ST_LAST_CHK: begin
				state_nxt = stat.last ? gle_pkg::ST_EMIT_LPFX : gle_pkg::ST_IDLE;
			end
			gle_pkg::ST_EMIT_LPFX:  state_nxt = gle_pkg::ST_DRAIN_LPFX;
			gle_pkg::ST_DRAIN_LPFX: begin
				if (!stat.ge8) state_nxt = gle_pkg::ST_EMIT_END;
			end
			gle_pkg::ST_EMIT_END:   state_nxt = gle_pkg::ST_DRAIN_END;
			gle_pkg::ST_DRAIN_END: begin
				if (!stat.ge8) state_nxt = gle_pkg::ST_FLUSH;
			end
			gle_pkg::ST_FLUSH: begin
				if (!stat.bnz || stat.out_free) state_nxt = gle_pkg::ST_IDLE;
			end
			default: state_nxt = gle_pkg::ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd = '0;
		cmd.emit_sel = gle_pkg::SEL_CLEAR;
		pixel_stall = (state_q != gle_pkg::ST_IDLE);
		case (state_q)
			gle_pkg::ST_IDLE:     cmd.accept = pixel_valid;
			gle_pkg::ST_INIT:     cmd.init = 1'b1;
			gle_pkg::ST_EMIT_CLR: begin
				cmd.emit = 1'b1;
				cmd.emit_sel = gle_pkg::SEL_CLEAR;
			end
			gle_pkg::ST_DRAIN_CLR: cmd.drain = 1'b1;
			gle_pkg::ST_SYM: begin
				cmd.first_sym = !stat.pvalid;
				cmd.srch_start = stat.pvalid;
			end
			gle_pkg::ST_SEARCH: begin
				cmd.srch_run = 1'b1;
				cmd.take_hit = stat.srch_hit;
			end
			gle_pkg::ST_EMIT_PFX: begin
				cmd.emit = 1'b1;
				cmd.emit_sel = gle_pkg::SEL_PREFIX;
			end
			gle_pkg::ST_DRAIN_PFX: cmd.drain = 1'b1;
			gle_pkg::ST_UPDATE:    cmd.update = 1'b1;
			gle_pkg::ST_EMIT_FULL: begin
				cmd.emit = 1'b1;
				cmd.emit_sel = gle_pkg::SEL_CLEAR;
			end
			gle_pkg::ST_DRAIN_FULL: cmd.drain = 1'b1;
			gle_pkg::ST_RESTART:    cmd.restart = 1'b1;
			gle_pkg::ST_LAST_CHK: begin
			end
			gle_pkg::ST_EMIT_LPFX: begin
				cmd.emit = 1'b1;
				cmd.emit_sel = gle_pkg::SEL_PREFIX;
			end
			gle_pkg::ST_DRAIN_LPFX: cmd.drain = 1'b1;
			gle_pkg::ST_EMIT_END: begin
				cmd.emit = 1'b1;
				cmd.emit_sel = gle_pkg::SEL_END;
			end
			gle_pkg::ST_DRAIN_END: begin
				cmd.drain = 1'b1;
				cmd.final_flag = 1'b1;
			end
			gle_pkg::ST_FLUSH: begin
				cmd.flush = 1'b1;
				cmd.finish = !stat.bnz || stat.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

### hw/rtl/gle_datapath.sv
// Dictionary memory, code state, bit packer and output register of the LZW encoder.
`default_nettype none
`include "gif_lzw_encoder_core_assert.svh"
module gle_datapath #(
	parameter int MAX_CODE_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [gle_pkg::SIZE_W-1:0]    cfg_data,
	input  wire gle_pkg::pixel_t               pixel,
	output gle_pkg::stream_t                   stream,
	output logic                               stream_valid,
	input  wire logic                          stream_stall,
	input  wire gle_pkg::cmd_t                 cmd,
	output gle_pkg::stat_t                     stat
);

	localparam int CW    = MAX_CODE_BITS;
	localparam int NFW   = MAX_CODE_BITS + 1;
	localparam int DEPTH = 1 << MAX_CODE_BITS;
	localparam int EW    = MAX_CODE_BITS + gle_pkg::SYM_W;
	localparam int SW    = gle_pkg::SIZE_W;
	localparam int AW    = gle_pkg::ACC_W;
	localparam int BW    = gle_pkg::BCNT_W;

	logic [SW-1:0]  min_size_q, active_q, width_q;
	logic [NFW-1:0] nf_q, ra_q;
	logic [CW-1:0]  prefix_q, ra_s1;
	logic           pvalid_q, started_q, last_q, rv_s1;
	logic [AW-1:0]  acc_q;
	logic [BW-1:0]  bcnt_q;
	logic [7:0]     pix_q;
	logic [EW-1:0]  rdata_s1;
	logic [EW-1:0]  dict_mem [DEPTH];
	logic           out_valid_q;
	gle_pkg::stream_t out_q;

	logic [SW-1:0]  size_eff;
	logic [CW-1:0]  clear_c, end_c, code_c;
	logic [7:0]     sym;
	logic [EW-1:0]  key;
	logic [AW-1:0]  code_mask, acc_emit;
	logic [NFW-1:0] nf_inc;
	logic           full_nxt, grow, issue, hit, out_free, push, push_last;

	// Code and symbol arithmetic.
	always_comb begin
		size_eff  = gle_pkg::eff_size(min_size_q);
		clear_c   = CW'(1) << active_q;
		end_c     = clear_c + CW'(1);
		sym       = pix_q & 8'((9'd1 << active_q) - 9'd1);
		key       = {prefix_q, sym};
		case (cmd.emit_sel)
			gle_pkg::SEL_CLEAR:  code_c = clear_c;
			gle_pkg::SEL_PREFIX: code_c = prefix_q;
			gle_pkg::SEL_END:    code_c = end_c;
			default:             code_c = clear_c;
		endcase
		code_mask = (AW'(1) << width_q) - AW'(1);
		acc_emit  = acc_q | ((AW'(code_c) & code_mask) << bcnt_q);
		nf_inc    = nf_q + NFW'(1);
		full_nxt  = nf_inc >= NFW'(DEPTH);
		grow      = (nf_inc == (NFW'(1) << width_q)) && (width_q < SW'(MAX_CODE_BITS));
		issue     = cmd.srch_run && (ra_q < nf_q);
		hit       = rv_s1 && (rdata_s1 == key);
		out_free  = !out_valid_q || !stream_stall;
		push      = out_free && ((cmd.drain && (bcnt_q >= BW'(8))) ||
		                         (cmd.flush && (bcnt_q != '0)));
		push_last = cmd.flush || (cmd.final_flag && (bcnt_q == BW'(8)));
	end

	// Configuration register and per-stream code state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_size_q <= SW'(gle_pkg::SIZE_RST);
			active_q   <= SW'(gle_pkg::SIZE_RST);
			nf_q       <= (NFW'(1) << gle_pkg::SIZE_RST) + NFW'(2);
			width_q    <= SW'(gle_pkg::SIZE_RST + 1);
			prefix_q   <= '0;
			pvalid_q   <= 1'b0;
			started_q  <= 1'b0;
			last_q     <= 1'b0;
			pix_q      <= '0;
		end else begin
			if (cfg_valid) min_size_q <= cfg_data;
			if (cmd.accept) begin
				pix_q  <= pixel.pixel_index;
				last_q <= pixel.last_pixel;
			end
			if (cmd.init) begin
				active_q  <= size_eff;
				nf_q      <= (NFW'(1) << size_eff) + NFW'(2);
				width_q   <= size_eff + SW'(1);
				pvalid_q  <= 1'b0;
				started_q <= 1'b1;
			end
			if (cmd.restart) begin
				nf_q    <= NFW'(clear_c) + NFW'(2);
				width_q <= active_q + SW'(1);
			end
			if (cmd.first_sym) begin
				prefix_q <= CW'(sym);
				pvalid_q <= 1'b1;
			end
			if (cmd.take_hit) prefix_q <= ra_s1;
			if (cmd.update) begin
				nf_q     <= nf_inc;
				prefix_q <= CW'(sym);
				if (!full_nxt && grow) width_q <= width_q + SW'(1);
			end
			if (cmd.finish) begin
				started_q <= 1'b0;
				pvalid_q  <= 1'b0;
				prefix_q  <= '0;
			end
		end
	end

	// Bit accumulator: append a code, shift out one byte, or clear on init and after the flush byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			bcnt_q <= '0;
		end else if (cmd.init) begin
			acc_q  <= '0;
			bcnt_q <= '0;
		end else if (cmd.emit) begin
			acc_q  <= acc_emit;
			bcnt_q <= bcnt_q + BW'(width_q);
		end else if (push && cmd.flush) begin
			acc_q  <= '0;
			bcnt_q <= '0;
		end else if (push) begin
			acc_q  <= acc_q >> 8;
			bcnt_q <= bcnt_q - BW'(8);
		end
	end

	// Linear dictionary scan, one entry read per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ra_q  <= '0;
			rv_s1 <= 1'b0;
		end else if (cmd.srch_start) begin
			ra_q  <= NFW'(clear_c) + NFW'(2);
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= issue;
			if (issue) ra_q <= ra_q + NFW'(1);
		end
	end

	// Dictionary memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.update) dict_mem[nf_q[CW-1:0]] <= key;
		if (issue) begin
			rdata_s1 <= dict_mem[ra_q[CW-1:0]];
			ra_s1    <= ra_q[CW-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!stream_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q.out_byte  <= acc_q[7:0];
			out_q.last_byte <= push_last;
		end
	end

	assign stream       = out_q;
	assign stream_valid = out_valid_q;

	always_comb begin
		stat.started   = started_q;
		stat.pvalid    = pvalid_q;
		stat.last      = last_q;
		stat.ge8       = bcnt_q >= BW'(8);
		stat.bnz       = bcnt_q != '0;
		stat.out_free  = out_free;
		stat.srch_done = hit || (!rv_s1 && !(ra_q < nf_q));
		stat.srch_hit  = hit;
		stat.full      = full_nxt;
	end

	// A code is appended only after the accumulator has been drained.
	`GLE_ASSERT_IMP(a_emit_drained, cmd.emit, bcnt_q < BW'(8), "emit with full byte pending")
	// The final byte of a stream leaves no bits behind.
	`GLE_ASSERT_NXT(a_last_empties, push && push_last, bcnt_q == '0, "bits left after last byte")
	// Dictionary writes stay inside the table.
	`GLE_ASSERT_IMP(a_write_range, cmd.update, nf_q < NFW'(DEPTH), "write beyond dictionary")
	// Code width never exceeds the maximum.
	`GLE_ASSERT_IMP(a_width_max, started_q, width_q <= SW'(MAX_CODE_BITS), "code width too large")

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the GIF LZW encoder core with a built-in code stream predictor.
`default_nettype none
module tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int IDLE_PAUSE = 5000;
	localparam int DICT_SIZE = 4096;
	localparam int CODE_BITS = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [gle_pkg::SIZE_W-1:0] cfg_data = '0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	gle_pkg::pixel_t pixel = '0;
	logic stream_valid;
	logic stream_stall = 1'b0;
	gle_pkg::stream_t stream;

	gif_lzw_encoder_core #(.MAX_CODE_BITS(CODE_BITS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.stream_valid(stream_valid),
		.stream_stall(stream_stall),
		.stream(stream)
	);

	always #6 clk = ~clk;

	// Predictor state: the encoder's dictionary, prefix, width and bit packer.
	logic [19:0] code_table [DICT_SIZE];
	int unsigned next_code, prefix_code, code_bits, bit_acc, bit_cnt, stream_size, size_reg;
	bit prefix_live, in_stream;
	int unsigned bytes_this_pixel;
	gle_pkg::stream_t step_bytes[$];
	gle_pkg::stream_t expected_bytes[$];

	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit no_idling = 1'b0;

	// Append one code to the bit packer and move out whole bytes.
	function void pack_code(input int unsigned code, input int unsigned width);
		gle_pkg::stream_t b;
		bit_acc |= (code & ((1 << width) - 1)) << bit_cnt;
		bit_cnt += width;
		while (bit_cnt >= 8) begin
			if (bytes_this_pixel < 8) begin
				b.out_byte = bit_acc[7:0];
				b.last_byte = 1'b0;
				step_bytes.push_back(b);
				bytes_this_pixel++;
			end
			bit_acc >>= 8;
			bit_cnt -= 8;
		end
		bit_acc &= 32'hFF_FFFF;
	endfunction

	function void restart_codes();
		next_code = (1 << stream_size) + 2;
		code_bits = stream_size + 1;
	endfunction

	// Work out the bytes that one pixel transfer produces; they land in step_bytes.
	function void predict_pixel(input gle_pkg::pixel_t p);
		int unsigned sym, key, idx, clr;
		bit hit;
		step_bytes.delete();
		bytes_this_pixel = 0;
		hit = 1'b0;
		if (!in_stream) begin
			stream_size = size_reg < gle_pkg::SIZE_LO ? gle_pkg::SIZE_LO :
				(size_reg > gle_pkg::SIZE_HI ? gle_pkg::SIZE_HI : size_reg);
			restart_codes();
			prefix_live = 1'b0;
			bit_acc = 0;
			bit_cnt = 0;
			in_stream = 1'b1;
			pack_code(1 << stream_size, code_bits);
		end
		clr = 1 << stream_size;
		sym = p.pixel_index & ((1 << stream_size) - 1);
		if (!prefix_live) begin
			prefix_code = sym;
			prefix_live = 1'b1;
		end else begin
			key = (prefix_code << 8) | sym;
			for (idx = clr + 2; idx < next_code && idx < DICT_SIZE; idx++) begin
				if (!hit && code_table[idx] == key[19:0]) begin
					prefix_code = idx;
					hit = 1'b1;
				end
			end
			if (!hit) begin
				pack_code(prefix_code, code_bits);
				if (next_code < (1 << CODE_BITS))
					code_table[next_code] = key[19:0];
				next_code++;
				if (next_code >= (1 << CODE_BITS)) begin
					pack_code(clr, code_bits);
					restart_codes();
				end else if (next_code == (1 << code_bits) && code_bits < CODE_BITS) begin
					code_bits++;
				end
				prefix_code = sym;
			end
		end
		if (p.last_pixel) begin
			pack_code(prefix_code, code_bits);
			pack_code(clr + 1, code_bits);
			if (bit_cnt > 0) begin
				if (bytes_this_pixel < 8) begin
					step_bytes.push_back('{out_byte: bit_acc[7:0], last_byte: 1'b0});
					bytes_this_pixel++;
				end
				bit_acc = 0;
				bit_cnt = 0;
			end
			if (step_bytes.size() > 0)
				step_bytes[step_bytes.size()-1].last_byte = 1'b1;
			in_stream = 1'b0;
			prefix_live = 1'b0;
			prefix_code = 0;
		end
	endfunction

	// Receiver side: random stall bursts, none in the closing phase.
	int unsigned stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (!no_idling && $urandom_range(0, 5) == 0) begin
			stream_stall <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else begin
			stream_stall <= 1'b0;
		end
	end

	// Check each byte transfer against the oldest expectation; also run the watchdog.
	always @(negedge clk) begin
		gle_pkg::stream_t want;
		if (arst_n) begin
			if (stream_valid && !stream_stall) begin
				if (expected_bytes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected byte transfer: %h last %b",
							stream.out_byte, stream.last_byte);
				end else begin
					want = expected_bytes.pop_front();
					if (want.out_byte !== stream.out_byte ||
						want.last_byte !== stream.last_byte) begin
						mismatches++;
						if (mismatches <= 10)
							$display("byte mismatch: expected %h last %b, got %h last %b",
								want.out_byte, want.last_byte, stream.out_byte,
								stream.last_byte);
					end
				end
			end
			if ((stream_valid && !stream_stall) || (pixel_valid && !pixel_stall) ||
				(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Write the minimum code size register through its own channel.
	task automatic write_size(input int unsigned v);
		bit ok;
		cfg_data <= v[gle_pkg::SIZE_W-1:0];
		cfg_valid <= 1'b1;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		size_reg = v & 4'hF;
	endtask

	// Send one pixel; typed_cnt > 0 replaces the predicted bytes with typed ones.
	task automatic send_pixel(input gle_pkg::pixel_t p, input int typed_cnt = 0,
		input logic [31:0] typed = '0);
		bit ok;
		int i;
		if (!no_idling && $urandom_range(0, 3) == 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		pixel <= p;
		pixel_valid <= 1'b1;
		do begin
			@(negedge clk);
			ok = !pixel_stall;
			if (ok) begin
				predict_pixel(p);
				if (typed_cnt > 0) begin
					step_bytes.delete();
					for (i = 0; i < typed_cnt; i++)
						step_bytes.push_back('{out_byte: typed[8*i +: 8],
							last_byte: i == typed_cnt - 1});
				end
				foreach (step_bytes[i])
					expected_bytes.push_back(step_bytes[i]);
			end
			@(posedge clk);
		end while (!ok);
	endtask

	// Let every result arrive and the block go idle before a register write.
	task automatic drain_to_idle();
		pixel_valid <= 1'b0;
		while (expected_bytes.size() > 0) @(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	// Random streams, mostly with small alphabets so strings repeat and the dictionary grows.
	task automatic random_phase(input int n_items);
		int unsigned run_len, alpha, k;
		gle_pkg::pixel_t p;
		int sent;
		sent = 0;
		while (sent < n_items) begin
			run_len = $urandom_range(1, 30);
			alpha = $urandom_range(0, 3);
			for (k = 0; k < run_len && sent < n_items; k++) begin
				case (alpha)
					0: p.pixel_index = 8'($urandom_range(0, 1));
					1: p.pixel_index = 8'($urandom_range(0, 3) | ($urandom_range(0, 63) << 2));
					2: p.pixel_index = 8'($urandom_range(0, 7));
					default: p.pixel_index = 8'($urandom_range(0, 255));
				endcase
				// The last item of a phase sometimes leaves its stream open.
				p.last_pixel = (k == run_len - 1) || (sent == n_items - 1 && $urandom_range(0, 1));
				send_pixel(p);
				sent++;
			end
		end
	endtask

	typedef struct {
		logic [7:0]  pix;
		logic        last;
		int          n_typed;
		logic [31:0] typed;
	} pixel_row_t;

	pixel_row_t dir_rows[] = '{
		'{8'h00, 1'b1, 2, 32'h0144}, '{8'h03, 1'b1, 2, 32'h015C}, '{8'hFF, 1'b1, 2, 32'h015C},
		'{8'h01, 1'b0, 0, 0}, '{8'h01, 1'b0, 0, 0}, '{8'h01, 1'b0, 0, 0},
		'{8'h01, 1'b0, 0, 0}, '{8'h01, 1'b0, 0, 0}, '{8'h01, 1'b0, 0, 0},
		'{8'h00, 1'b1, 0, 0}, '{8'h02, 1'b0, 0, 0}, '{8'h03, 1'b0, 0, 0},
		'{8'h02, 1'b0, 0, 0}, '{8'h03, 1'b0, 0, 0}, '{8'h02, 1'b0, 0, 0},
		'{8'h03, 1'b0, 0, 0}, '{8'h02, 1'b0, 0, 0}, '{8'h03, 1'b0, 0, 0},
		'{8'h80, 1'b0, 0, 0}, '{8'h7F, 1'b0, 0, 0}, '{8'hAA, 1'b0, 0, 0},
		'{8'h55, 1'b1, 0, 0}, '{8'h04, 1'b0, 0, 0}
	};

	int unsigned phase_sizes[] = '{8, 0, 15, 5, 3, 2};

	initial begin
		gle_pkg::pixel_t p;
		size_reg = gle_pkg::SIZE_RST;
		in_stream = 1'b0;
		prefix_live = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the smallest code size.
		write_size(2);
		foreach (dir_rows[i]) begin
			p.pixel_index = dir_rows[i].pix;
			p.last_pixel = dir_rows[i].last;
			send_pixel(p, dir_rows[i].n_typed, dir_rows[i].typed);
		end

		// Random phases, each at its own code size; the last one runs without idling.
		foreach (phase_sizes[i]) begin
			drain_to_idle();
			if (i == phase_sizes.size() - 1)
				no_idling = 1'b1;
			write_size(phase_sizes[i]);
			random_phase(35);
		end

		pixel_valid <= 1'b0;
		while (expected_bytes.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
